// ===== src/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared sizes, codes and controller/datapath interface types for the
// bounded double-ended queue engine.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  // Request codes
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_BACK   = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_LIST_START,
    OP_LIST_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_valid;
    logic [1:0] res_status;
    logic       res_last;
    logic       res_from_mem;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic list_last;
  } dp_sts_t;

  // Ring position base + off, with off below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== src/bounded_deque_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// A push or pop result appears in the cycle after the item is taken;
//   busy stays low, so a push or pop item can be taken every cycle.
// A list of N elements holds busy while it steps through them after the item is
//   taken and emits one result per cycle; the single read port of the ring
//   store sets that pace. An empty list answers like a pop.
// Results cannot be stalled. Synchronous active-low reset empties the queue.
module bounded_deque_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_item_value,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import bde_pkg::*;

  // Command from the sequencer and status back from the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Decode requests against full/empty, and walk the store for a list
  bde_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Hold the ring store and pointers; register every result item
  bde_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== src/bde_ctrl.sv =====
// ----------------------------------------------------------------------------
// bde_ctrl
// Request decoder and list sequencer; issues one datapath command a cycle.
// ----------------------------------------------------------------------------
module bde_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2:0]      in_req_type,
  input  bde_pkg::dp_sts_t sts,
  output bde_pkg::dp_cmd_t cmd,
  output logic            busy
);
  import bde_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_LIST);

  always_comb begin
    state_nxt        = state_r;
    cmd.op           = OP_NONE;
    cmd.res_valid    = 1'b0;
    cmd.res_status   = STS_OK;
    cmd.res_last     = 1'b1;
    cmd.res_from_mem = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              cmd.res_valid = 1'b1;
              if (sts.full) begin
                cmd.res_status = STS_FULL;
              end else begin
                cmd.op = (in_req_type == REQ_PUSH_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
              end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
              cmd.res_valid = 1'b1;
              if (sts.empty) begin
                cmd.res_status = STS_EMPTY;
              end else begin
                cmd.op = (in_req_type == REQ_POP_BACK) ? OP_POP_BACK : OP_POP_FRONT;
              end
            end
            REQ_LIST: begin
              if (sts.empty) begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = STS_EMPTY;
              end else begin
                cmd.op    = OP_LIST_START;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              // drop unused request codes
            end
          endcase
        end
      end
      ST_LIST: begin
        cmd.op           = OP_LIST_STEP;
        cmd.res_valid    = 1'b1;
        cmd.res_last     = sts.list_last;
        cmd.res_from_mem = 1'b1;
        if (sts.list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bde_datapath.sv =====
// ----------------------------------------------------------------------------
// bde_datapath
// Ring store, front index, element count, list cursor and result registers.
// ----------------------------------------------------------------------------
module bde_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [31:0]     in_value,
  input  bde_pkg::dp_cmd_t       cmd,
  output bde_pkg::dp_sts_t       sts,
  output logic                   out_valid,
  output logic signed [31:0]     out_item_value,
  output logic [1:0]             out_status,
  output logic                   out_last
);
  import bde_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              valid_r;
  logic [1:0]        status_r;
  logic              last_r;
  logic              from_mem_r;

  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  front_prev;
  logic [IDX_W-1:0]  front_next;

  assign front_prev = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_next = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign rd_addr    = ring_add(front_r, idx_r);

  assign sts.full      = (count_r == CNT_W'(DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.list_last = ((idx_r + 1'b1) == count_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = ring_add(front_r, count_r);
    case (cmd.op)
      OP_PUSH_BACK: begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      OP_PUSH_FRONT: begin
        wr_en     = 1'b1;
        wr_addr   = front_prev;
        front_nxt = front_prev;
        count_nxt = count_r + 1'b1;
      end
      OP_POP_BACK: begin
        count_nxt = count_r - 1'b1;
      end
      OP_POP_FRONT: begin
        front_nxt = front_next;
        count_nxt = count_r - 1'b1;
      end
      OP_LIST_START: begin
        idx_nxt = '0;
      end
      OP_LIST_STEP: begin
        idx_nxt = idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      valid_r <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= cmd.res_status;
    last_r     <= cmd.res_last;
    from_mem_r <= cmd.res_from_mem;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LIST_STEP) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid      = valid_r;
  assign out_item_value = from_mem_r ? rd_data_r : '0;
  assign out_status     = status_r;
  assign out_last       = last_r;

endmodule

// ===== src/bde_checker.sv =====
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks on the deque engine, bound to the top level.
// ----------------------------------------------------------------------------
module bde_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_req_type,
  input logic               out_valid,
  input logic signed [31:0] out_item_value,
  input logic [1:0]         out_status,
  input logic               out_last
);
  import bde_pkg::*;

  // A push or pop item gives exactly one closing result in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_PUSH_BACK || in_req_type == REQ_PUSH_FRONT ||
     in_req_type == REQ_POP_BACK || in_req_type == REQ_POP_FRONT))
    |=> (out_valid && out_last && !busy))
    else $error("push/pop item did not give one result");

  // Unused request codes give no result
  a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type > REQ_LIST) |=> !out_valid)
    else $error("unused request code produced a result");

  // Error results stand alone and carry zero
  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_OK) |-> (out_last && out_item_value == '0))
    else $error("error result not final or not zero");

  // A listing in progress keeps the engine busy
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("engine idle during a listing");

  // Reset clears any pending result and drops busy
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("reset left a result or busy");

endmodule

bind bounded_deque_engine bde_checker u_bde_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded double-ended queue engine. A queue of
// requests (directed corner cases, then random fill, drain and mixed bursts)
// feeds a clocked driver; every accepted item is run through a local deque
// model that queues the status or list results it should produce, and a
// monitor compares each strobed result against the oldest of them.
// ----------------------------------------------------------------------------
module tb_top;
  import bde_pkg::*;

  localparam int N_RANDOM   = 300;
  localparam int CYCLE_CAP  = 200000;
  localparam int SETTLE_CYC = 2 * DEPTH + 8;

  typedef struct {
    logic [2:0]               req;
    logic signed [DATA_W-1:0] value;
    int unsigned              gap;        // idle cycles before this item
    bit                       wait_drain; // hold until all results are back
  } deque_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] item_value;
    logic [1:0]               status;
    logic                     is_last;
  } deque_res_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               in_req_type = REQ_PUSH_BACK;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_item_value;
  logic [1:0]               out_status;
  logic                     out_last;

  deque_req_t pending_q[$];
  deque_res_t expected_q[$];

  // Deque model: ring contents, front position and fill level
  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned front_pos = 0;
  int unsigned held = 0;

  // Fill level as seen by the stimulus generator (steers fill/drain bursts)
  int unsigned plan_level = 0;
  int          n_planned = 0;
  int          n_mismatch = 0;
  int          cycle_cnt = 0;
  int unsigned idle_run = 0;

  bounded_deque_engine u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model: apply one accepted request and queue the results it must produce
  // --------------------------------------------------------------------------
  function automatic void queue_result(input logic signed [DATA_W-1:0] v,
                                       input logic [1:0] s, input logic l);
    deque_res_t r;
    r.item_value = v;
    r.status     = s;
    r.is_last    = l;
    expected_q.push_back(r);
  endfunction

  function automatic void apply_deque_request(input logic [2:0] req,
                                              input logic signed [DATA_W-1:0] v);
    int unsigned k;
    case (req)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (held == DEPTH) begin
          queue_result('0, STS_FULL, 1'b1);
        end else begin
          if (req == REQ_PUSH_BACK) begin
            ring_mem[(front_pos + held) % DEPTH] = v;
          end else begin
            front_pos = (front_pos + DEPTH - 1) % DEPTH;
            ring_mem[front_pos] = v;
          end
          held++;
          queue_result('0, STS_OK, 1'b1);
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (held == 0) begin
          queue_result('0, STS_EMPTY, 1'b1);
        end else begin
          // Popped value is not reported; only the ends move
          if (req == REQ_POP_FRONT) begin
            front_pos = (front_pos + 1) % DEPTH;
          end
          held--;
          queue_result('0, STS_OK, 1'b1);
        end
      end
      REQ_LIST: begin
        if (held == 0) begin
          queue_result('0, STS_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < held; k++) begin
            queue_result(ring_mem[(front_pos + k) % DEPTH], STS_OK, k == held - 1);
          end
        end
      end
      default: ;  // unused codes: no state change, no result
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly no gap or a short one, now and then a long pause; style 0 means a
  // back-to-back stretch.
  function automatic int unsigned pick_gap(input int style);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (style == 0) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Append one request; track the fill level and count it unless it is ignored.
  function automatic void plan_req(input logic [2:0] req, input logic signed [DATA_W-1:0] v,
                                   input int style, input bit drain);
    deque_req_t it;
    it.req        = req;
    it.value      = v;
    it.gap        = pick_gap(style);
    it.wait_drain = drain;
    pending_q.push_back(it);
    case (req)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: if (plan_level < DEPTH) plan_level++;
      REQ_POP_BACK, REQ_POP_FRONT:   if (plan_level > 0) plan_level--;
      default: ;
    endcase
    if (req <= REQ_LIST) n_planned++;
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: take the next pending item once the current one is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic slot_free;
    if (!rst_n) begin
      start    <= 1'b0;
      idle_run = 0;
    end else begin
      slot_free = !start || !busy;
      // Item taken at this edge: predict its results now
      if (start && !busy) begin
        apply_deque_request(in_req_type, in_value);
      end
      if (slot_free) begin
        if (pending_q.size() != 0 && idle_run >= pending_q[0].gap &&
            (!pending_q[0].wait_drain || expected_q.size() == 0)) begin
          start       <= 1'b1;
          in_req_type <= pending_q[0].req;
          in_value    <= pending_q[0].value;
          void'(pending_q.pop_front());
          idle_run = 0;
        end else begin
          // Hold off: gap still running, drain pending or nothing left
          start <= 1'b0;
          idle_run++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample mid-cycle, away from the driving edge
  // --------------------------------------------------------------------------
  function automatic void log_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  always @(negedge clk) begin
    deque_res_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result value %0d status %0d last %0b",
                               out_item_value, out_status, out_last));
      end else begin
        want = expected_q.pop_front();
        if (out_item_value !== want.item_value || out_status !== want.status ||
            out_last !== want.is_last) begin
          log_mismatch($sformatf(
            "expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
            want.item_value, want.status, want.is_last,
            out_item_value, out_status, out_last));
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build all items, release reset, wait for drain, report
  // --------------------------------------------------------------------------
  initial begin
    int style;
    int phase;
    int k;
    int n_ops;
    int r;

    // Directed part: empty-store corners, ignored codes, lone-element pops,
    // signed extremes at both ends, wrap of the front position.
    plan_req(REQ_LIST,       $urandom, 1, 1'b0);
    plan_req(REQ_POP_BACK,   $urandom, 1, 1'b0);
    plan_req(REQ_POP_FRONT,  $urandom, 1, 1'b0);
    plan_req(3'd5,           $urandom, 1, 1'b0);
    plan_req(3'd6,           $urandom, 1, 1'b0);
    plan_req(3'd7,           $urandom, 1, 1'b0);
    plan_req(REQ_PUSH_BACK,  32'sh8000_0000, 1, 1'b0);
    plan_req(REQ_LIST,       $urandom, 1, 1'b0);
    plan_req(REQ_POP_BACK,   $urandom, 1, 1'b0);
    plan_req(REQ_LIST,       $urandom, 1, 1'b0);
    plan_req(REQ_PUSH_FRONT, 32'sh7fff_ffff, 1, 1'b0);
    plan_req(REQ_POP_FRONT,  $urandom, 1, 1'b0);
    plan_req(REQ_PUSH_FRONT, -32'sd1, 0, 1'b0);
    plan_req(REQ_PUSH_BACK,  '0, 0, 1'b0);
    plan_req(REQ_PUSH_FRONT, 32'sd1, 0, 1'b0);
    plan_req(REQ_PUSH_BACK,  32'sh5555_5555, 0, 1'b0);
    plan_req(REQ_PUSH_FRONT, 32'shaaaa_aaaa, 0, 1'b0);
    plan_req(REQ_LIST,       $urandom, 0, 1'b0);
    plan_req(REQ_POP_BACK,   $urandom, 1, 1'b1);
    plan_req(REQ_POP_FRONT,  $urandom, 1, 1'b0);
    plan_req(REQ_LIST,       $urandom, 1, 1'b0);
    plan_req(REQ_POP_FRONT,  $urandom, 1, 1'b0);
    plan_req(REQ_POP_BACK,   $urandom, 1, 1'b0);
    plan_req(REQ_POP_BACK,   $urandom, 1, 1'b0);
    plan_req(REQ_LIST,       $urandom, 1, 1'b0);

    // Random part in bursts: fill to full and past it, drain past empty,
    // or a mixed run; each burst has its own idling style.
    while (n_planned < N_RANDOM) begin
      style = $urandom_range(0, 2);
      phase = $urandom_range(0, 9);
      // Sometimes hold the burst until every pending result is back
      plan_req(pick_push(), pick_value(), style, $urandom_range(0, 3) == 0);
      if (phase < 3) begin
        while (plan_level < DEPTH) plan_req(pick_push(), pick_value(), style, 1'b0);
        n_ops = $urandom_range(1, 2);
        for (k = 0; k < n_ops; k++) plan_req(pick_push(), pick_value(), style, 1'b0);
        plan_req(REQ_LIST, $urandom, style, 1'b0);
      end else if (phase < 5) begin
        while (plan_level > 0) plan_req(pick_pop(), $urandom, style, 1'b0);
        n_ops = $urandom_range(1, 2);
        for (k = 0; k < n_ops; k++) plan_req(pick_pop(), $urandom, style, 1'b0);
        plan_req(REQ_LIST, $urandom, style, 1'b0);
      end else begin
        n_ops = $urandom_range(4, 16);
        for (k = 0; k < n_ops; k++) begin
          r = $urandom_range(0, 19);
          if (r < 8)       plan_req(pick_push(), pick_value(), style, 1'b0);
          else if (r < 14) plan_req(pick_pop(), $urandom, style, 1'b0);
          else if (r < 18) plan_req(REQ_LIST, $urandom, style, 1'b0);
          else             plan_req(3'($urandom_range(5, 7)), $urandom, style, 1'b0);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is taken and every result has come back
    do @(negedge clk);
    while (pending_q.size() != 0 || start || expected_q.size() != 0);
    // Let any stray results show up
    repeat (SETTLE_CYC) @(negedge clk);

    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
